@@ rtl/core/cby_pkg.sv @@
// ----------------------------------------------------------------------------
// cby_pkg
// shared widths, types, register codes and rounding helpers for the
// bezier easing solver
// ----------------------------------------------------------------------------
package cby_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_ITER  = 50;
    localparam int TBITS     = FRAC_BITS + 8;
    localparam int VW        = FRAC_BITS + 1;   // value width, Q1.FRAC_BITS
    localparam int TW        = TBITS + 1;       // curve parameter width
    localparam int WW        = TBITS + 2;       // weight width, up to 3.0
    localparam int PW        = WW + TW;         // product width
    localparam int MW        = 14;              // rounded ten-thousandths
    localparam int ITW       = $clog2(MAX_ITER);
    localparam int CFG_IW    = 3;

    typedef logic [VW-1:0]     t_val;
    typedef logic [TW-1:0]     t_tv;
    typedef logic [WW-1:0]     t_wop;
    typedef logic [PW-1:0]     t_prod;
    typedef logic [MW-1:0]     t_match;
    typedef logic [ITW-1:0]    t_iter;
    typedef logic [CFG_IW-1:0] t_cfg_idx;

    localparam t_val   ONE_V       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam t_tv    ONE_T       = {1'b1, {TBITS{1'b0}}};
    localparam t_match MATCH_SCALE = t_match'(10000);
    localparam t_iter  LAST_ITER   = t_iter'(MAX_ITER - 1);

    localparam t_cfg_idx CFG_CTRL1_X = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_CTRL1_Y = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_CTRL2_X = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_CTRL2_Y = t_cfg_idx'(3);

    typedef struct packed {
        t_val c1x;
        t_val c1y;
        t_val c2x;
        t_val c2y;
    } t_ctrl_pts;

    function automatic t_val sat_val(input t_val v);
        return (v > ONE_V) ? ONE_V : v;
    endfunction

    // product of two parameter-format numbers, rounded half up
    function automatic t_tv rnd_t(input t_prod p);
        t_prod s;
        s = p + (t_prod'(1) << (TBITS - 1));
        return t_tv'(s >> TBITS);
    endfunction

    function automatic t_wop triple(input t_tv r);
        return t_wop'(r) + (t_wop'(r) << 1);
    endfunction

    // weighted sum back to a saturated value
    function automatic t_val val_of_sum(input t_prod acc);
        t_prod s;
        t_prod q;
        s = acc + (t_prod'(1) << (TBITS - 1));
        q = s >> TBITS;
        return (q > t_prod'(ONE_V)) ? ONE_V : t_val'(q);
    endfunction

    function automatic t_match rnd_match(input t_prod p);
        t_prod s;
        s = p + (t_prod'(1) << (FRAC_BITS - 1));
        return t_match'(s >> FRAC_BITS);
    endfunction

endpackage

@@ rtl/core/cby_mul.sv @@
// ----------------------------------------------------------------------------
// cby_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module cby_mul (
    input  logic            i_clk,
    input  cby_pkg::t_wop   i_a,
    input  cby_pkg::t_tv    i_b,
    output cby_pkg::t_prod  o_prod
);

    cby_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= cby_pkg::t_prod'(i_a) * cby_pkg::t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/cby_cfg.sv @@
// ----------------------------------------------------------------------------
// cby_cfg
// control point registers, saturated to 1.0 on write
// ----------------------------------------------------------------------------
module cby_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  cby_pkg::t_cfg_idx   i_cfg_index,
    input  cby_pkg::t_val       i_cfg_data,
    output cby_pkg::t_ctrl_pts  o_pts
);

    cby_pkg::t_ctrl_pts r_pts;
    cby_pkg::t_val      w_data;

    assign o_cfg_ready = 1'b1;
    assign w_data      = cby_pkg::sat_val(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts.c1x <= '0;
            r_pts.c1y <= '0;
            r_pts.c2x <= cby_pkg::ONE_V;
            r_pts.c2y <= cby_pkg::ONE_V;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cby_pkg::CFG_CTRL1_X: r_pts.c1x <= w_data;
                cby_pkg::CFG_CTRL1_Y: r_pts.c1y <= w_data;
                cby_pkg::CFG_CTRL2_X: r_pts.c2x <= w_data;
                cby_pkg::CFG_CTRL2_Y: r_pts.c2y <= w_data;
                default: ;   // unmapped index, beat dropped
            endcase
        end
    end

    assign o_pts = r_pts;

endmodule

@@ rtl/core/cubic_bezier_y_for_x.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_y_for_x
// easing curve lookup: y of a cubic bezier from (0,0) to (1,1) at a given x
// ----------------------------------------------------------------------------
// usage
//   command channel: a beat is taken when i_start is high and o_busy is low;
//   i_target_x is Q1.16 and is saturated to 1.0
//   result: o_done strobes for one cycle with o_out_x (the saturated
//   target), o_out_y and o_no_root; the receiver cannot stall, so the
//   result must be captured in that cycle
//   config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data; ready is always high, write only while o_busy is low
// timing
//   the parameter is bisected; each step evaluates x(t) with seven products
//   on one shared multiplier, then scales x by 10000 for the match test
//   an item runs 1 to 50 bisection steps and then the y pass before
//   o_done; o_busy falls in the o_done cycle and the next command may be
//   taken there
// reset
//   synchronous active low; clears the sequencer and the strobe and loads
//   the control points with (0,0) and (1,1)
// ----------------------------------------------------------------------------
module cubic_bezier_y_for_x (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  cby_pkg::t_val      i_target_x,
    output logic               o_busy,
    output logic               o_done,
    output cby_pkg::t_val      o_out_x,
    output cby_pkg::t_val      o_out_y,
    output logic               o_no_root,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  cby_pkg::t_cfg_idx  i_cfg_index,
    input  cby_pkg::t_val      i_cfg_data
);

    // sequencer: goal scaling, then per step midpoint, curve evaluation
    // (E0..E8), x scaling and compare; the y evaluation reuses E0..E8
    typedef enum logic [3:0] {
        S_IDLE,
        S_GOAL_MUL,
        S_GOAL,
        S_MID,
        S_E0,
        S_E1,
        S_E2,
        S_E3,
        S_E4,
        S_E5,
        S_E6,
        S_E7,
        S_E8,
        S_XMUL,
        S_CMP
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic                r_no_root;
    logic                r_is_y;      // current evaluation is the y pass
    cby_pkg::t_val       r_target;
    cby_pkg::t_val       r_out_y;
    cby_pkg::t_val       r_val;       // x at the midpoint
    cby_pkg::t_match     r_goal;
    cby_pkg::t_iter      r_iter;
    cby_pkg::t_tv        r_lo;
    cby_pkg::t_tv        r_hi;
    cby_pkg::t_tv        r_t;
    cby_pkg::t_tv        r_u;         // 1 - t
    cby_pkg::t_tv        r_tt;
    cby_pkg::t_tv        r_uu;
    cby_pkg::t_tv        r_w3;
    cby_pkg::t_wop       r_w2;
    cby_pkg::t_wop       r_w1;
    cby_pkg::t_prod      r_acc;

    cby_pkg::t_ctrl_pts  w_pts;
    cby_pkg::t_wop       w_mul_a;
    cby_pkg::t_tv        w_mul_b;
    cby_pkg::t_prod      w_prod;
    cby_pkg::t_val       w_p1;
    cby_pkg::t_val       w_p2;
    logic [cby_pkg::TW:0] w_mid_sum;
    cby_pkg::t_tv        w_mid;
    cby_pkg::t_val       w_curve;
    logic                w_hit;
    logic                w_last;

    cby_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pts       (w_pts)
    );

    cby_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // inner points of the curve being evaluated
    assign w_p1 = r_is_y ? w_pts.c1y : w_pts.c1x;
    assign w_p2 = r_is_y ? w_pts.c2y : w_pts.c2x;

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[cby_pkg::TW:1];
    assign w_curve   = cby_pkg::val_of_sum(r_acc);
    assign w_hit     = (cby_pkg::rnd_match(w_prod) == r_goal);
    assign w_last    = (r_iter == cby_pkg::LAST_ITER);

    // multiplier operands; each multiplying state issues one product and the next
    // state takes it from the product register
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_GOAL_MUL: begin
                w_mul_a = cby_pkg::t_wop'(r_target);
                w_mul_b = cby_pkg::t_tv'(cby_pkg::MATCH_SCALE);
            end
            S_E0: begin
                w_mul_a = cby_pkg::t_wop'(r_t);
                w_mul_b = r_t;
            end
            S_E1: begin
                w_mul_a = cby_pkg::t_wop'(r_u);
                w_mul_b = r_u;
            end
            S_E2: begin
                w_mul_a = cby_pkg::t_wop'(r_tt);
                w_mul_b = r_t;
            end
            S_E3: begin
                w_mul_a = cby_pkg::t_wop'(r_tt);
                w_mul_b = r_u;
            end
            S_E4: begin
                w_mul_a = cby_pkg::t_wop'(r_uu);
                w_mul_b = r_t;
            end
            S_E5: begin
                w_mul_a = r_w2;
                w_mul_b = cby_pkg::t_tv'(w_p2);
            end
            S_E6: begin
                w_mul_a = r_w1;
                w_mul_b = cby_pkg::t_tv'(w_p1);
            end
            S_XMUL: begin
                w_mul_a = cby_pkg::t_wop'(r_val);
                w_mul_b = cby_pkg::t_tv'(cby_pkg::MATCH_SCALE);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_target <= cby_pkg::sat_val(i_target_x);
                        r_lo     <= '0;
                        r_hi     <= cby_pkg::ONE_T;
                        r_iter   <= '0;
                        r_is_y   <= 1'b0;
                        r_state  <= S_GOAL_MUL;
                    end
                end
                S_GOAL_MUL: r_state <= S_GOAL;
                S_GOAL: begin
                    r_goal  <= cby_pkg::rnd_match(w_prod);
                    r_state <= S_MID;
                end
                S_MID: begin
                    r_t     <= w_mid;
                    r_u     <= cby_pkg::ONE_T - w_mid;
                    r_state <= S_E0;
                end
                S_E0: r_state <= S_E1;
                S_E1: begin
                    r_tt    <= cby_pkg::rnd_t(w_prod);
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_uu    <= cby_pkg::rnd_t(w_prod);
                    r_state <= S_E3;
                end
                S_E3: begin
                    r_w3    <= cby_pkg::rnd_t(w_prod);
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_w2    <= cby_pkg::triple(cby_pkg::rnd_t(w_prod));
                    r_state <= S_E5;
                end
                S_E5: begin
                    r_w1    <= cby_pkg::triple(cby_pkg::rnd_t(w_prod));
                    r_state <= S_E6;
                end
                S_E6: begin
                    // w2*p2 plus the end point term w3*1.0
                    r_acc   <= w_prod + (cby_pkg::t_prod'(r_w3) << cby_pkg::FRAC_BITS);
                    r_state <= S_E7;
                end
                S_E7: begin
                    r_acc   <= r_acc + w_prod;
                    r_state <= S_E8;
                end
                S_E8: begin
                    if (r_is_y) begin
                        r_out_y <= w_curve;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_val   <= w_curve;
                        r_state <= S_XMUL;
                    end
                end
                S_XMUL: r_state <= S_CMP;
                S_CMP: begin
                    if (r_val < r_target) begin
                        r_lo <= r_t;
                    end else begin
                        r_hi <= r_t;
                    end
                    if (w_hit || w_last) begin
                        // y at the same midpoint
                        r_no_root <= !w_hit;
                        r_is_y    <= 1'b1;
                        r_state   <= S_E0;
                    end else begin
                        r_iter  <= r_iter + 1'b1;
                        r_state <= S_MID;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_out_x   = r_target;
    assign o_out_y   = r_out_y;
    assign o_no_root = r_no_root;

endmodule

@@ rtl/core/cby_chk.sv @@
// ----------------------------------------------------------------------------
// cby_chk
// port level checks of command and result sequencing
// ----------------------------------------------------------------------------
module cby_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input logic               o_cfg_ready
);

    // a taken command keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("command beat not followed by busy");

    // a result beat only closes a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy && $past(o_busy)))
        else $error("result beat outside a busy period");

    // a result beat is not repeated back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat repeated");

    // config channel never stalls, checked while busy
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> o_cfg_ready)
        else $error("config channel stalled");

endmodule

bind cubic_bezier_y_for_x cby_chk u_cby_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_cfg_ready (o_cfg_ready)
);
